### hw/rtl/shabs_pkg.sv
package shabs_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_ABSORB = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_e;

	typedef struct packed {
		cmd_e       cmd;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last;
	} result_t;

	// One message word on its way from the front to the core.
	typedef struct packed {
		logic [31:0] word;
		logic        final_block;
	} word_entry_t;

	typedef enum logic {
		FRONT_ABSORB,
		FRONT_PAD
	} front_state_e;

	typedef enum logic [1:0] {
		CORE_LOAD,
		CORE_ROUND,
		CORE_UPDATE
	} core_state_e;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INITIAL_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

### hw/rtl/shabs_front.sv
module shabs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  shabs_pkg::item_t      item,
	output logic                  q_push,
	output shabs_pkg::word_entry_t q_entry,
	input  logic                  q_full
);

	shabs_pkg::front_state_e state_q, state_d;

	logic [23:0] acc_q;
	logic [1:0]  byte_cnt_q;
	logic [3:0]  word_cnt_q;
	logic [60:0] msg_bytes_q;
	logic [63:0] len_q;
	logic        len_ok_q;

	logic        absorb_go;
	logic        finish_go;
	logic [31:0] pad_word;

	always_comb begin
		case (byte_cnt_q)
			2'd0:    pad_word = {shabs_pkg::PAD_BYTE, 24'h0};
			2'd1:    pad_word = {acc_q[7:0], shabs_pkg::PAD_BYTE, 16'h0};
			2'd2:    pad_word = {acc_q[15:0], shabs_pkg::PAD_BYTE, 8'h0};
			default: pad_word = {acc_q[23:0], shabs_pkg::PAD_BYTE};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shabs_pkg::FRONT_ABSORB;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		full      = 1'b1;
		absorb_go = 1'b0;
		finish_go = 1'b0;
		q_push    = 1'b0;
		q_entry   = '0;
		case (state_q)
			shabs_pkg::FRONT_ABSORB: begin
				full = q_full;
				if (push && !q_full) begin
					if (item.cmd == shabs_pkg::CMD_ABSORB) begin
						absorb_go = 1'b1;
						q_push    = (byte_cnt_q == 2'd3);
						q_entry.word = {acc_q, item.data_byte};
					end else begin
						finish_go    = 1'b1;
						q_push       = 1'b1;
						q_entry.word = pad_word;
						state_d      = shabs_pkg::FRONT_PAD;
					end
				end
			end
			shabs_pkg::FRONT_PAD: begin
				if (!q_full) begin
					q_push = 1'b1;
					if (len_ok_q && word_cnt_q == 4'd14) begin
						q_entry.word = len_q[63:32];
					end else if (len_ok_q && word_cnt_q == 4'd15) begin
						q_entry.word        = len_q[31:0];
						q_entry.final_block = 1'b1;
						state_d             = shabs_pkg::FRONT_ABSORB;
					end
				end
			end
			default: begin
				state_d = shabs_pkg::FRONT_ABSORB;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q  <= '0;
			word_cnt_q  <= '0;
			msg_bytes_q <= '0;
			len_ok_q    <= 1'b0;
		end else begin
			if (absorb_go) begin
				byte_cnt_q  <= byte_cnt_q + 2'd1;
				msg_bytes_q <= msg_bytes_q + 61'd1;
				if (byte_cnt_q == 2'd3) begin
					word_cnt_q <= word_cnt_q + 4'd1;
				end
			end
			if (finish_go) begin
				byte_cnt_q  <= '0;
				msg_bytes_q <= '0;
				word_cnt_q  <= word_cnt_q + 4'd1;
				len_ok_q    <= (word_cnt_q != 4'd14);
			end
			if (state_q == shabs_pkg::FRONT_PAD && q_push) begin
				word_cnt_q <= word_cnt_q + 4'd1;
				if (word_cnt_q == 4'd15) begin
					len_ok_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (absorb_go) begin
			acc_q <= {acc_q[15:0], item.data_byte};
		end
		if (finish_go) begin
			len_q <= {msg_bytes_q, 3'b000};
		end
	end

endmodule

### hw/rtl/shabs_queue.sv
module shabs_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  shabs_pkg::word_entry_t wr_data,
	output logic                   full,
	input  logic                   rd_en,
	output shabs_pkg::word_entry_t rd_data,
	output logic                   empty
);

	shabs_pkg::word_entry_t mem_q [shabs_pkg::QUEUE_DEPTH];

	logic [shabs_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [shabs_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [shabs_pkg::QUEUE_CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full    = (count_q == shabs_pkg::QUEUE_CNT_W'(shabs_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + shabs_pkg::QUEUE_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + shabs_pkg::QUEUE_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + shabs_pkg::QUEUE_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - shabs_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### hw/rtl/shabs_core.sv
module shabs_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  shabs_pkg::word_entry_t q_entry,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  logic                   pop,
	output logic                   empty,
	output shabs_pkg::result_t     result
);

	shabs_pkg::core_state_e state_q, state_d;

	logic [5:0]  cnt_q;
	logic        final_q;
	logic [31:0] h_q   [8];
	logic [31:0] v_q   [8];
	logic [31:0] win_q [16];
	logic [31:0] dig_q [8];
	logic        dig_busy_q;
	logic [2:0]  dig_idx_q;

	logic        round_go;
	logic        update_go;
	logic        dig_pop;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_next;
	logic [31:0] sum [8];

	always_comb begin
		t1 = v_q[7] + shabs_pkg::big_sigma1(v_q[4])
		   + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		   + shabs_pkg::ROUND_K[cnt_q] + win_q[0];
		t2 = shabs_pkg::big_sigma0(v_q[0])
		   + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_next = win_q[0] + shabs_pkg::small_sigma0(win_q[1]) + win_q[9]
		       + shabs_pkg::small_sigma1(win_q[14]);
		for (int i = 0; i < 8; i++) begin
			sum[i] = h_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shabs_pkg::CORE_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		round_go  = 1'b0;
		update_go = 1'b0;
		case (state_q)
			shabs_pkg::CORE_LOAD: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (cnt_q[3:0] == 4'd15) begin
						state_d = shabs_pkg::CORE_ROUND;
					end
				end
			end
			shabs_pkg::CORE_ROUND: begin
				round_go = 1'b1;
				if (cnt_q == 6'd63) begin
					state_d = shabs_pkg::CORE_UPDATE;
				end
			end
			shabs_pkg::CORE_UPDATE: begin
				if (!(final_q && dig_busy_q)) begin
					update_go = 1'b1;
					state_d   = shabs_pkg::CORE_LOAD;
				end
			end
			default: begin
				state_d = shabs_pkg::CORE_LOAD;
			end
		endcase
	end

	assign dig_pop            = pop && dig_busy_q;
	assign empty              = !dig_busy_q;
	assign result.digest_word = dig_q[dig_idx_q];
	assign result.word_index  = dig_idx_q;
	assign result.last        = (dig_idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			final_q    <= 1'b0;
			h_q        <= shabs_pkg::INITIAL_HASH;
			dig_busy_q <= 1'b0;
			dig_idx_q  <= '0;
		end else begin
			if (q_pop) begin
				cnt_q   <= (cnt_q[3:0] == 4'd15) ? 6'd0 : cnt_q + 6'd1;
				final_q <= q_entry.final_block;
			end
			if (round_go) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (dig_pop) begin
				dig_idx_q <= dig_idx_q + 3'd1;
				if (dig_idx_q == 3'd7) begin
					dig_busy_q <= 1'b0;
				end
			end
			if (update_go) begin
				if (final_q) begin
					h_q        <= shabs_pkg::INITIAL_HASH;
					dig_busy_q <= 1'b1;
					dig_idx_q  <= '0;
				end else begin
					h_q <= sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= q_entry.word;
			if (cnt_q[3:0] == 4'd0) begin
				v_q <= h_q;
			end
		end
		if (round_go) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_next;
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
		if (update_go && final_q) begin
			dig_q <= sum;
		end
	end

endmodule

### hw/rtl/sha256_byte_stream_hasher.sv
// SHA-256 hasher that takes the message one byte per beat.
// The input channel is push/full with an item of cmd and data_byte. An absorb
// beat appends one byte, and a finish beat pads the message and ends it.
// The result channel is empty/pop. Each finish produces eight beats of
// digest_word, most significant word first, with word_index 0 to 7 and last
// set on the eighth. The block then starts over with the initial hash values.
// Bytes are taken at one per cycle while the word queue between the front end
// and the compression core has room. The core loads 16 words and then runs 64
// rounds and an update step. The queue holds four words, so the front end
// stalls during the rounds. After a finish the front end writes 2 to 17 more
// padding and length words, one per cycle while the queue has room, and full
// stays high until the last one is written. The digest is held in its own
// register set, so the core keeps hashing the next message while the receiver
// stalls; only a second finished digest waits until the first has been popped.
// Reset clears all counts, empties the queue and loads the initial hash values;
// no item is lost across a stall.
module sha256_byte_stream_hasher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  shabs_pkg::item_t   item,
	output logic               empty,
	input  logic               pop,
	output shabs_pkg::result_t result
);

	shabs_pkg::word_entry_t q_wr_entry;
	shabs_pkg::word_entry_t q_rd_entry;
	logic                   q_push;
	logic                   q_full;
	logic                   q_pop;
	logic                   q_empty;

	shabs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_push  (q_push),
		.q_entry (q_wr_entry),
		.q_full  (q_full)
	);

	shabs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_entry),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_entry),
		.empty   (q_empty)
	);

	shabs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_entry (q_rd_entry),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("Front end wrote into a full word queue.");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("Core read from an empty word queue.");

	a_last_matches_index: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.last == (result.word_index == 3'd7)))
		else $error("Last flag disagrees with the digest word index.");

	a_index_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last) |=>
			(!empty && result.word_index == $past(result.word_index) + 3'd1))
		else $error("Digest beats did not advance in order.");

endmodule

### tb/sha256_digest_checker.sv
module sha256_digest_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  shabs_pkg::item_t   item,
	input  logic               empty,
	input  logic               pop,
	input  shabs_pkg::result_t result,
	output int                 fail_count,
	output int                 pending_words
);

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int LENGTH_OFFSET = 56;
	localparam int BLOCK_SIZE = 64;

	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_START [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0]        hash_state [8];
	logic [7:0]         block_bytes [64];
	logic [5:0]         fill_count;
	logic [60:0]        message_len;
	shabs_pkg::result_t expected_words [$];

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void restart_message();
		int i;
		for (i = 0; i < 8; i++)
			hash_state[i] = H_START[i];
		fill_count = '0;
		message_len = '0;
	endfunction

	function automatic void compress_block_bytes();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		int i, j;
		for (i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
		for (i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (j = 7; j > 0; j--)
				v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		block_bytes[fill_count] = b;
		message_len = message_len + 1'b1;
		fill_count = fill_count + 1'b1;
		if (fill_count == '0)
			compress_block_bytes();
	endfunction

	function automatic void finish_message();
		logic [63:0]        bit_len;
		shabs_pkg::result_t word;
		int pos, i;
		bit_len = {message_len, 3'b000};
		pos = fill_count;
		block_bytes[pos] = PAD_MARK;
		pos++;
		if (pos > LENGTH_OFFSET) begin
			for (; pos < BLOCK_SIZE; pos++)
				block_bytes[pos] = 8'h00;
			compress_block_bytes();
			pos = 0;
		end
		for (; pos < LENGTH_OFFSET; pos++)
			block_bytes[pos] = 8'h00;
		for (i = 0; i < 8; i++)
			block_bytes[LENGTH_OFFSET + i] = bit_len[63 - 8*i -: 8];
		compress_block_bytes();
		for (i = 0; i < 8; i++) begin
			word.digest_word = hash_state[i];
			word.word_index = 3'(i);
			word.last = (i == 7);
			expected_words = {expected_words, word};
		end
		restart_message();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shabs_pkg::result_t want;
		if (!arst_n) begin
			restart_message();
			expected_words.delete();
			fail_count = 0;
			pending_words = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result beat: digest_word %h word_index %0d last %0b",
						result.digest_word, result.word_index, result.last);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (result.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, got %h",
							want.digest_word, result.digest_word);
						fail_count++;
					end
					if (result.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d",
							want.word_index, result.word_index);
						fail_count++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result.last);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				if (item.cmd == shabs_pkg::CMD_FINISH)
					finish_message();
				else
					absorb_byte(item.data_byte);
			end
			pending_words = expected_words.size();
		end
	end

endmodule

### tb/tb_top.sv
module tb_top;

	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 120;
	localparam int DRAIN_CYCLES = 200;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	shabs_pkg::item_t   item = '0;
	logic               empty;
	logic               pop = 1'b0;
	shabs_pkg::result_t result;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int fail_count;
	int pending_words;

	sha256_byte_stream_hasher u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	sha256_digest_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.item          (item),
		.empty         (empty),
		.pop           (pop),
		.result        (result),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("** sha256_byte_stream_hasher: FAILED **");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input shabs_pkg::cmd_e c, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= '{cmd: c, data_byte: b};
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	task automatic send_message(input int len);
		int i;
		for (i = 0; i < len; i++)
			send_beat(shabs_pkg::CMD_ABSORB, 8'($urandom_range(255)));
		send_beat(shabs_pkg::CMD_FINISH, 8'($urandom_range(255)));
	endtask

	task automatic hold_until_drained();
		push <= 1'b0;
		@(negedge clk);
		while (pending_words != 0)
			@(negedge clk);
	endtask

	// Mostly short messages, with lengths around the padding and block boundaries.
	function automatic int pick_length();
		int sel;
		sel = $urandom_range(9);
		if (sel <= 5)
			return $urandom_range(12);
		if (sel == 9)
			return $urandom_range(13, 70);
		case ($urandom_range(9))
			0: return 55;
			1: return 56;
			2: return 57;
			3: return 63;
			4: return 64;
			5: return 65;
			6: return 119;
			7: return 120;
			8: return 127;
			default: return 128;
		endcase
	endfunction

	initial begin
		int phase, sent, len;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_beat(shabs_pkg::CMD_FINISH, 8'hFF);
		send_beat(shabs_pkg::CMD_FINISH, 8'h00);
		send_beat(shabs_pkg::CMD_ABSORB, 8'h00);
		send_beat(shabs_pkg::CMD_FINISH, 8'h00);
		send_beat(shabs_pkg::CMD_ABSORB, 8'hFF);
		send_beat(shabs_pkg::CMD_FINISH, 8'h80);
		send_beat(shabs_pkg::CMD_ABSORB, 8'h61);
		send_beat(shabs_pkg::CMD_ABSORB, 8'h62);
		send_beat(shabs_pkg::CMD_ABSORB, 8'h63);
		send_beat(shabs_pkg::CMD_FINISH, 8'h55);
		send_message(5);
		hold_until_drained();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 84;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 84;
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct = 38;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = pick_length();
				send_message(len);
				sent += len + 1;
			end
			hold_until_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_words == 0)
			$display("** sha256_byte_stream_hasher: PASSED **");
		else
			$display("** sha256_byte_stream_hasher: FAILED **");
		$finish;
	end

endmodule
